// ===== sv/cfh_pkg.sv =====
// Shared constants, types and helpers for the CSV field djb2 hasher.
package cfh_pkg;

    localparam int OFFSET_BITS_DEFAULT = 40;
    localparam int LINE_OFFSET_BITS    = 40;
    localparam int KEY_HASH_BITS       = 64;
    localparam int CFG_DATA_BITS       = 8;

    localparam logic [KEY_HASH_BITS-1:0] DJB2_START = 64'd5381;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;

    // djb2 multiplier 33 = (1 << DJB2_SHIFT) + 1
    localparam int DJB2_SHIFT = 5;

    // configuration register indexes
    typedef enum logic {
        REG_FIELD_INDEX    = 1'b0,
        REG_KEY_CHAR_LIMIT = 1'b1
    } cfg_reg_t;

    // per-byte control handed to the field tracker
    typedef struct packed {
        logic advance;      // a byte transaction is accepted this cycle
        logic new_line;     // that byte is a newline
        logic reload_skip;  // field_index written at the start of a line
    } cfh_step_t;

    // commas to pass before the selected field; index zero acts as one
    function automatic logic [7:0] skip_count(input logic [7:0] fi);
        logic [7:0] r;
        r = (fi == 8'd0) ? 8'd0 : fi - 8'd1;
        return r;
    endfunction

endpackage

// ===== sv/csv_field_djb2_hasher.sv =====
// Top level of the CSV field djb2 hasher: byte position, config and result register.
//
// Usage:
//   s_ channel: one byte of CSV text per transaction (s_data_byte); 0x0A ends a line.
//   m_ channel: one transaction per newline, carrying the djb2 hash of the selected
//   field (m_key_hash) and the byte offset at which that line began (m_line_offset).
//   cfg port: cfg_we/cfg_index/cfg_wdata write field_index (0) or key_char_limit (1)
//   in the same cycle; write only while no byte is in flight.
// Timing:
//   One byte per cycle, except while s_ready is low (below). A byte's state update
//   happens in the cycle it is accepted; a newline's result is on m_ the next cycle.
//   The limit is the single result register: while it holds a result the receiver
//   has not taken, s_ready stays low; s_ready is high whenever m_ready is high.
// Reset (aresetn, synchronous, active low): position and line start go to zero,
//   field_index to 1, key_char_limit to 32, the hash to 5381, no result pending.
// A last line with no newline never produces a result transaction.
module csv_field_djb2_hasher #(
    parameter int OFFSET_BITS = cfh_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // byte input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    // line result
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cfh_pkg::KEY_HASH_BITS-1:0]    m_key_hash,
    output logic [cfh_pkg::LINE_OFFSET_BITS-1:0] m_line_offset,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [cfh_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import cfh_pkg::*;

    // configuration registers
    logic [7:0] field_index_reg;
    logic [7:0] key_char_limit_reg;

    // position tracking
    logic [OFFSET_BITS-1:0] byte_position_reg, byte_position_next;
    logic [OFFSET_BITS-1:0] line_start_reg, line_start_next;
    logic [63:0]            line_start_wide;

    // result register
    logic                        m_valid_reg, m_valid_next;
    logic [KEY_HASH_BITS-1:0]    m_key_hash_reg;
    logic [LINE_OFFSET_BITS-1:0] m_line_offset_reg;

    logic                     accept;
    logic                     is_newline;
    logic [KEY_HASH_BITS-1:0] running_hash;
    cfh_step_t                step;

    // Result register frees when its transaction completes, so a stalled
    // receiver only blocks input while a result is still pending.
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign is_newline = (s_data_byte == CHAR_NEWLINE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg    <= 8'd1;
            key_char_limit_reg <= 8'd32;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_FIELD_INDEX:    field_index_reg    <= cfg_wdata;
                REG_KEY_CHAR_LIMIT: key_char_limit_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // A new field_index takes effect at once only if the current line has
    // not seen a byte yet; otherwise it waits for the next newline.
    always_comb begin
        step.advance     = accept;
        step.new_line    = is_newline;
        step.reload_skip = cfg_we && (cfg_reg_t'(cfg_index) == REG_FIELD_INDEX)
                           && (byte_position_reg == line_start_reg);
    end

    cfh_field_tracker u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .data_byte       (s_data_byte),
        .field_index     (field_index_reg),
        .key_char_limit  (key_char_limit_reg),
        .new_field_index (cfg_wdata),
        .running_hash    (running_hash)
    );

    // Positions wrap at 2^OFFSET_BITS.
    always_comb begin
        byte_position_next = byte_position_reg;
        line_start_next    = line_start_reg;
        if (accept) begin
            byte_position_next = byte_position_reg + 1'b1;
            if (is_newline) begin
                line_start_next = byte_position_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && is_newline) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            line_start_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            byte_position_reg <= byte_position_next;
            line_start_reg    <= line_start_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // line_offset is the line start zero-extended or cut to 40 bits
    assign line_start_wide = 64'(line_start_reg);

    always_ff @(posedge aclk) begin
        if (accept && is_newline) begin
            m_key_hash_reg    <= running_hash;
            m_line_offset_reg <= line_start_wide[LINE_OFFSET_BITS-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_key_hash    = m_key_hash_reg;
    assign m_line_offset = m_line_offset_reg;

    // Input is held off only while a result waits for the receiver.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("s_ready low with empty result register");

    // A non-newline byte never creates a result transaction.
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_newline && !m_valid_reg) |=> !m_valid_reg)
        else $error("result raised without a newline");

    // After a newline the new line starts at the current position with a fresh hash.
    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_newline) |=>
            (line_start_reg == byte_position_reg) && (running_hash == DJB2_START))
        else $error("line state not restarted after newline");

endmodule

// ===== sv/cfh_field_tracker.sv =====
// Per-line field selection and djb2 hash accumulation.
module cfh_field_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cfh_pkg::cfh_step_t               step,
    input  logic [7:0]                       data_byte,
    input  logic [7:0]                       field_index,
    input  logic [7:0]                       key_char_limit,
    input  logic [7:0]                       new_field_index,
    output logic [cfh_pkg::KEY_HASH_BITS-1:0] running_hash
);
    import cfh_pkg::*;

    logic [7:0]               commas_to_skip_reg, commas_to_skip_next;
    logic [7:0]               kept_count_reg, kept_count_next;
    logic                     field_closed_reg, field_closed_next;
    logic [KEY_HASH_BITS-1:0] running_hash_reg, running_hash_next;
    logic [KEY_HASH_BITS-1:0] hash_mixed;

    assign hash_mixed = (running_hash_reg << DJB2_SHIFT) + running_hash_reg
                      + {{(KEY_HASH_BITS-8){1'b0}}, data_byte};

    always_comb begin
        commas_to_skip_next = commas_to_skip_reg;
        kept_count_next     = kept_count_reg;
        field_closed_next   = field_closed_reg;
        running_hash_next   = running_hash_reg;
        if (step.advance) begin
            if (step.new_line) begin
                commas_to_skip_next = skip_count(field_index);
                kept_count_next     = 8'd0;
                field_closed_next   = 1'b0;
                running_hash_next   = DJB2_START;
            end else if (!field_closed_reg) begin
                if (data_byte == CHAR_NUL) begin
                    field_closed_next = 1'b1;
                end else if (commas_to_skip_reg != 8'd0) begin
                    if (data_byte == CHAR_COMMA) begin
                        commas_to_skip_next = commas_to_skip_reg - 8'd1;
                    end
                end else if (kept_count_reg >= key_char_limit || data_byte == CHAR_COMMA) begin
                    field_closed_next = 1'b1;
                end else if (data_byte != CHAR_QUOTE) begin
                    running_hash_next = hash_mixed;
                    kept_count_next   = kept_count_reg + 8'd1;
                end
            end
        end else if (step.reload_skip) begin
            commas_to_skip_next = skip_count(new_field_index);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            commas_to_skip_reg <= 8'd0;
            kept_count_reg     <= 8'd0;
            field_closed_reg   <= 1'b0;
            running_hash_reg   <= DJB2_START;
        end else begin
            commas_to_skip_reg <= commas_to_skip_next;
            kept_count_reg     <= kept_count_next;
            field_closed_reg   <= field_closed_next;
            running_hash_reg   <= running_hash_next;
        end
    end

    assign running_hash = running_hash_reg;

endmodule

// ===== verif/line_hash_checker.sv =====
// Checker for the CSV field djb2 hasher: predicts each line result and compares it.
`timescale 1ns / 1ps

module line_hash_checker #(
    parameter int OFFSET_BITS = cfh_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [cfh_pkg::KEY_HASH_BITS-1:0]    m_key_hash,
    input  logic [cfh_pkg::LINE_OFFSET_BITS-1:0] m_line_offset,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [cfh_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output int                                   fail_count,
    output int                                   pending_lines
);
    import cfh_pkg::*;

    typedef struct packed {
        logic [KEY_HASH_BITS-1:0]    key_hash;
        logic [LINE_OFFSET_BITS-1:0] line_offset;
    } line_result_t;

    localparam int MAX_REPORTS = 10;

    // mirrored block state
    logic [OFFSET_BITS-1:0]   byte_pos;
    logic [OFFSET_BITS-1:0]   line_begin;
    logic [7:0]               commas_left;
    logic [7:0]               kept_chars;
    logic                     field_done;
    logic [KEY_HASH_BITS-1:0] djb2_acc;
    logic [7:0]               key_field;
    logic [7:0]               char_limit;

    line_result_t expected_lines[$];
    int errors = 0;
    int reports = 0;

    function automatic logic [7:0] commas_for(input logic [7:0] field_no);
        logic [7:0] n;
        n = (field_no == 8'd0) ? 8'd0 : field_no - 8'd1;
        return n;
    endfunction

    task automatic open_line();
        commas_left = commas_for(key_field);
        kept_chars  = 8'd0;
        field_done  = 1'b0;
        djb2_acc    = DJB2_START;
    endtask

    task automatic take_byte(input logic [7:0] b);
        line_result_t done_line;
        logic [63:0]  begin_wide;
        if (b == CHAR_NEWLINE) begin
            begin_wide            = 64'(line_begin);
            done_line.key_hash    = djb2_acc;
            done_line.line_offset = begin_wide[LINE_OFFSET_BITS-1:0];
            expected_lines = {expected_lines, done_line};
            byte_pos   = byte_pos + 1'b1;
            line_begin = byte_pos;
            open_line();
        end else begin
            if (!field_done) begin
                if (b == CHAR_NUL) begin
                    field_done = 1'b1;
                end else if (commas_left != 8'd0) begin
                    if (b == CHAR_COMMA) commas_left = commas_left - 8'd1;
                end else if (kept_chars >= char_limit || b == CHAR_COMMA) begin
                    field_done = 1'b1;
                end else if (b != CHAR_QUOTE) begin
                    djb2_acc   = (djb2_acc << DJB2_SHIFT) + djb2_acc + 64'(b);
                    kept_chars = kept_chars + 8'd1;
                end
            end
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    always @(posedge aclk) begin : track
        line_result_t oldest;
        if (!aresetn) begin
            key_field  = 8'd1;
            char_limit = 8'd32;
            byte_pos   = '0;
            line_begin = '0;
            open_line();
            expected_lines.delete();
        end else begin
            // result side first: a newline taken at this edge shows up in the next cycle
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("unexpected result: hash %h offset %0d",
                                 m_key_hash, m_line_offset);
                    end
                end else begin
                    oldest = expected_lines.pop_front();
                    if (oldest.key_hash !== m_key_hash ||
                        oldest.line_offset !== m_line_offset) begin
                        errors++;
                        if (reports < MAX_REPORTS) begin
                            reports++;
                            $display("mismatch: hash exp %h got %h, offset exp %0d got %0d",
                                     oldest.key_hash, m_key_hash,
                                     oldest.line_offset, m_line_offset);
                        end
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_reg_t'(cfg_index) == REG_FIELD_INDEX) begin
                    key_field = cfg_wdata;
                    // nothing of this line seen yet: new field applies at once
                    if (byte_pos == line_begin) commas_left = commas_for(key_field);
                end else begin
                    char_limit = cfg_wdata;
                end
            end
            if (s_valid && s_ready) take_byte(s_data_byte);
        end
        fail_count    <= errors;
        pending_lines <= expected_lines.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the CSV field djb2 hasher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import cfh_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int RANDOM_ITEMS    = 850;  // byte target for the whole run
    localparam int PHASE_MIN_ITEMS = 24;   // random bytes every phase gets at least
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 200000;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_data_byte;
    logic                        m_valid;
    logic                        m_ready;
    logic [KEY_HASH_BITS-1:0]    m_key_hash;
    logic [LINE_OFFSET_BITS-1:0] m_line_offset;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_wdata;

    int  fail_count;
    int  pending_lines;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    bit  idle_on = 1'b1;        // random gaps on both channels
    int  stall_left = 0;
    logic [7:0] sel_field = 8'd1; // field the stimulus aims its key at

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    csv_field_djb2_hasher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_hash    (m_key_hash),
        .m_line_offset (m_line_offset),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    line_hash_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_hash    (m_key_hash),
        .m_line_offset (m_line_offset),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_lines (pending_lines)
    );

    // Watchdog: a hang or a missing result ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side backpressure: m_ready drops in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    = 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    // One byte transaction. Starts at a falling edge, may insert a short gap,
    // then holds valid and the byte until the rising edge that takes it.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) push_byte(txt[i]);
    endtask

    // Drop valid and wait out every pending line result, so nothing is in flight
    // when a register changes.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_lines != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Field content: mostly printable, some quotes, rare NULs, some raw bytes.
    // Commas and newlines are kept out so the line shape stays as planned.
    function automatic logic [7:0] field_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 70)      c = 8'($urandom_range(8'h20, 8'h7E));
        else if (r < 82) c = CHAR_QUOTE;
        else if (r < 84) c = CHAR_NUL;
        else             c = 8'($urandom_range(0, 255));
        if (c == CHAR_COMMA || c == CHAR_NEWLINE) c = 8'h41;
        return c;
    endfunction

    // A CSV line: ncommas separators, the aimed field key_len bytes long,
    // other fields short. ends_line=0 leaves the line open (for mid-line writes).
    task automatic push_csv_line(input int ncommas, input int key_len, input bit ends_line);
        int flen;
        for (int f = 0; f <= ncommas; f++) begin
            flen = (f == int'(sel_field) - 1) ? key_len : $urandom_range(0, 5);
            for (int k = 0; k < flen; k++) push_byte(field_char());
            if (f < ncommas) push_byte(CHAR_COMMA);
        end
        if (ends_line) push_byte(CHAR_NEWLINE);
    endtask

    // Raw noise: any byte value, commas and newlines a bit more often.
    task automatic push_noise();
        int n;
        int r;
        n = $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 11);
            if (r == 0)      push_byte(CHAR_NEWLINE);
            else if (r == 1) push_byte(CHAR_COMMA);
            else             push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] phase_fields [NUM_PHASES];
        logic [7:0] phase_limits [NUM_PHASES];
        int stop_at;
        int kind;
        int far_commas;
        int far_key;

        // register settings per phase: index zero, 255, limit 0 and 255 among them
        phase_fields = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd3, 8'd1, 8'd0, 8'd0};
        phase_limits = '{8'd32, 8'd5, 8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0};
        phase_fields[6] = 8'($urandom_range(1, 255));
        phase_limits[6] = 8'($urandom_range(0, 255));
        phase_fields[7] = 8'($urandom_range(1, 4));
        phase_limits[7] = 8'($urandom_range(2, 40));

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        cfg_we      = 1'b0;
        cfg_index   = REG_FIELD_INDEX;
        cfg_wdata   = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed lines under the reset settings (field 1, limit 32).
        push_text("k1\n");                  // plain single field
        push_text("\"q\",x\n");             // quotes dropped, comma ends the key
        push_byte(CHAR_NUL);                // NUL closes the line's usable text
        push_text("a\n");
        push_byte(CHAR_NEWLINE);            // empty line
        push_byte(8'hFF);                   // byte extremes, taken unsigned
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'h01);
        push_byte(CHAR_NEWLINE);
        push_text(",z\n");                  // empty first field

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            // one phase runs without gaps, and so does the tail of the run
            idle_on = (phase != 3) && (phase != NUM_PHASES - 1);
            write_reg(REG_FIELD_INDEX, phase_fields[phase]);
            write_reg(REG_KEY_CHAR_LIMIT, phase_limits[phase]);
            sel_field = (phase_fields[phase] == 8'd0) ? 8'd1 : phase_fields[phase];

            // a key long enough to run into a large limit
            if (phase_limits[phase] >= 8'd200 && sel_field <= 8'd8)
                push_csv_line(sel_field + 1, $urandom_range(250, 270), 1'b1);
            // enough commas to reach a far field, or fall just short of it;
            // the other fields stay empty to keep the line short
            if (sel_field >= 8'd200) begin
                far_commas = int'(sel_field) + int'($urandom_range(0, 4)) - 3;
                far_key    = $urandom_range(0, 12);
                for (int f = 0; f <= far_commas; f++) begin
                    if (f == int'(sel_field) - 1) begin
                        for (int k = 0; k < far_key; k++) push_byte(field_char());
                    end
                    if (f < far_commas) push_byte(CHAR_COMMA);
                end
                push_byte(CHAR_NEWLINE);
            end

            // long lines above count against the run's byte target
            stop_at = (RANDOM_ITEMS * (phase + 1)) / NUM_PHASES;
            if (stop_at < bytes_sent + PHASE_MIN_ITEMS) stop_at = bytes_sent + PHASE_MIN_ITEMS;
            while (bytes_sent < stop_at) begin
                kind = $urandom_range(0, 19);
                if (kind < 15)
                    push_csv_line($urandom_range(0, 5), $urandom_range(0, 12), 1'b1);
                else if (kind < 17)
                    push_noise();
                else if (kind < 19) begin
                    // broken line: NUL in the first field, rest of line must be ignored
                    push_text("ab");
                    push_byte(CHAR_NUL);
                    push_text(",cd\n");
                end else
                    push_csv_line($urandom_range(0, 5), $urandom_range(0, 40), 1'b1);
            end

            // about half the phases, chosen at random, stop mid-line so the next writes land inside a line
            if ($urandom_range(0, 1) == 1)
                push_csv_line($urandom_range(0, 2), $urandom_range(1, 6), 1'b0);
        end

        // close whatever line is open, then leave a last line unterminated
        push_byte(CHAR_NEWLINE);
        push_text("tail,no,newline");
        settle();

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
